// ===== sv/ppg_heart_rate_detector_assert.svh =====
// ----------------------------------------------------------------------------
// PPG heart-rate detector assertion macros
// Concurrent assertion wrappers shared by the detector RTL.
// ----------------------------------------------------------------------------
`ifndef PPG_HEART_RATE_DETECTOR_ASSERT_SVH
`define PPG_HEART_RATE_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define HRD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hrd assertion failed");
// check on every clock edge, reset included
`define HRD_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hrd assertion failed");
`else
`define HRD_ASSERT(name, clk, rst_n, prop)
`define HRD_ASSERT_NR(name, clk, prop)
`endif

`endif

// ===== sv/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Heart-rate detector package
// Types, register map, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam int CONTACT_BITS  = 18;
  localparam int REG_BITS      = 16;
  localparam int BPM_BITS      = 16;
  localparam int MOTION_BITS   = 16;

  localparam int          COEF_BITS  = 11;
  localparam int          COEF_SHIFT = 16;
  localparam int unsigned COEF_NEW   = 655;
  localparam int unsigned ROUND_HALF = 32768;

  localparam int DIV_N_BITS   = 24;
  localparam int DIV_D_BITS   = 16;
  localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS);

  localparam logic [DIV_N_BITS-1:0] BPM_NUMER   = 24'd15360000;
  localparam int                    BLEND_BITS  = BPM_BITS + 3;
  localparam logic [BLEND_BITS-1:0] BLEND_RND   = 19'd2;
  localparam int                    RECIP_BITS  = 20;
  localparam int                    RECIP_SHIFT = 22;
  localparam logic [RECIP_BITS-1:0] BLEND_RECIP = 20'd838861;
  localparam logic [BPM_BITS-1:0]   BPM_MAX     = 16'hFFFF;

  localparam logic [CONTACT_BITS-1:0] RST_CONTACT  = 18'd3000;
  localparam logic [REG_BITS-1:0]     RST_PEAK     = 16'd50;
  localparam logic [REG_BITS-1:0]     RST_TROUGH   = 16'd15;
  localparam logic [REG_BITS-1:0]     RST_MIN_IVL  = 16'd375;
  localparam logic [REG_BITS-1:0]     RST_MAX_IVL  = 16'd1200;
  localparam logic [REG_BITS-1:0]     RST_MOTION   = 16'd14000;
  localparam logic [REG_BITS-1:0]     RST_JUMP     = 16'd8960;
  localparam logic [REG_BITS-1:0]     RST_INIT_BPM = 16'd19200;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONTACT,
    CFG_PEAK,
    CFG_TROUGH,
    CFG_MIN_IVL,
    CFG_MAX_IVL,
    CFG_MOTION,
    CFG_JUMP,
    CFG_INIT_BPM
  } hrd_cfg_idx_e;

  typedef struct packed {
    logic [CONTACT_BITS-1:0] contact;
    logic [REG_BITS-1:0]     peak;
    logic [REG_BITS-1:0]     trough;
    logic [REG_BITS-1:0]     min_ivl;
    logic [REG_BITS-1:0]     max_ivl;
    logic [REG_BITS-1:0]     motion;
    logic [REG_BITS-1:0]     jump;
    logic [REG_BITS-1:0]     init_bpm;
  } hrd_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EVAL,
    ST_RAW,
    ST_JUDGE,
    ST_BLEND,
    ST_OUT
  } hrd_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIV_N_BITS-1:0] dividend;
    logic [DIV_D_BITS-1:0] divisor;
  } hrd_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_N_BITS-1:0] quotient;
  } hrd_div_rsp_t;

endpackage

// ===== sv/hrd_if.sv =====
// ----------------------------------------------------------------------------
// Heart-rate detector stream interfaces
// Valid/ready channels for sample words in and result words out.
// ----------------------------------------------------------------------------
interface hrd_in_if #(
  parameter int SAMPLE_BITS = 18,
  parameter int TIME_BITS   = 32
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] ir_sample;
  logic [TIME_BITS-1:0]   time_ms;
  logic [15:0]            motion_magnitude;

  modport source (output valid, ir_sample, time_ms, motion_magnitude, input ready);
  modport sink   (input valid, ir_sample, time_ms, motion_magnitude, output ready);
endinterface

interface hrd_out_if #(
  parameter int SAMPLE_BITS = 18
);
  logic                      valid;
  logic                      ready;
  logic [15:0]               bpm_estimate;
  logic signed [SAMPLE_BITS:0] ac_level;
  logic                      beat_seen;
  logic                      beat_accepted;
  logic                      no_contact;

  modport source (output valid, bpm_estimate, ac_level, beat_seen, beat_accepted,
                  no_contact, input ready);
  modport sink   (input valid, bpm_estimate, ac_level, beat_seen, beat_accepted,
                  no_contact, output ready);
endinterface

// ===== sv/hrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Heart-rate detector configuration registers
// Write-only register file holding thresholds, window and BPM settings.
// ----------------------------------------------------------------------------
module hrd_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hrd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [hrd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output hrd_pkg::hrd_cfg_t                  cfg_o
);
  import hrd_pkg::*;

  hrd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contact  <= RST_CONTACT;
      cfg_q.peak     <= RST_PEAK;
      cfg_q.trough   <= RST_TROUGH;
      cfg_q.min_ivl  <= RST_MIN_IVL;
      cfg_q.max_ivl  <= RST_MAX_IVL;
      cfg_q.motion   <= RST_MOTION;
      cfg_q.jump     <= RST_JUMP;
      cfg_q.init_bpm <= RST_INIT_BPM;
    end else if (cfg_we_i) begin
      unique case (hrd_cfg_idx_e'(cfg_idx_i))
        CFG_CONTACT:  cfg_q.contact  <= cfg_data_i[CONTACT_BITS-1:0];
        CFG_PEAK:     cfg_q.peak     <= cfg_data_i[REG_BITS-1:0];
        CFG_TROUGH:   cfg_q.trough   <= cfg_data_i[REG_BITS-1:0];
        CFG_MIN_IVL:  cfg_q.min_ivl  <= cfg_data_i[REG_BITS-1:0];
        CFG_MAX_IVL:  cfg_q.max_ivl  <= cfg_data_i[REG_BITS-1:0];
        CFG_MOTION:   cfg_q.motion   <= cfg_data_i[REG_BITS-1:0];
        CFG_JUMP:     cfg_q.jump     <= cfg_data_i[REG_BITS-1:0];
        CFG_INIT_BPM: cfg_q.init_bpm <= cfg_data_i[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/hrd_div.sv =====
// ----------------------------------------------------------------------------
// Heart-rate detector serial divider
// Restoring divider, one quotient bit per cycle, used by the raw BPM step.
// ----------------------------------------------------------------------------
module hrd_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrd_pkg::hrd_div_req_t req_i,
  output hrd_pkg::hrd_div_rsp_t rsp_o
);
  import hrd_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(DIV_N_BITS - 1);

  logic [DIV_D_BITS:0]     rem_q;
  logic [DIV_N_BITS-1:0]   quo_q;
  logic [DIV_D_BITS-1:0]   dsr_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    busy_q;
  logic                    done_q;

  logic [DIV_D_BITS:0] rem_sh;
  logic                fits;
  logic [DIV_D_BITS:0] rem_nxt;

  assign rem_sh  = {rem_q[DIV_D_BITS-1:0], quo_q[DIV_N_BITS-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_nxt = fits ? rem_sh - {1'b0, dsr_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[DIV_N_BITS-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `include "ppg_heart_rate_detector_assert.svh"

  `HRD_ASSERT(a_start_when_free, clk_i, rst_ni, req_i.start |-> !busy_q)
  `HRD_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `HRD_ASSERT(a_last_step_done, clk_i, rst_ni, busy_q && cnt_q == CNT_LAST && !req_i.start |=> done_q)

endmodule

// ===== sv/ppg_heart_rate_detector.sv =====
// ----------------------------------------------------------------------------
// PPG heart-rate detector
// DC removal, peak/trough beat detection and blended BPM estimate on
// infrared optical samples, under a small sequencer with a serial divider.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  in_i     in   valid/ready        ir_sample, time_ms, motion_magnitude
//  out_o    out  valid/ready        bpm_estimate, ac_level, beat flags
//  cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
//  No-contact sample: IDLE, OUT; sample without a used beat: IDLE, MUL, ACC,
//  EVAL, OUT. A beat turned into a raw BPM waits in RAW for the 24-step serial
//  divider, then JUDGE, and BLEND if blended, a combinational multiply by 1/5.
//  One sample in flight; a finished word waits in the output register while
//  the next sample is taken. Async reset covers control, filter and beat state.
// ----------------------------------------------------------------------------
module ppg_heart_rate_detector #(
  parameter int SAMPLE_BITS = 18,
  parameter int TIME_BITS   = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hrd_in_if.sink                            in_i,
  hrd_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [hrd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [hrd_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import hrd_pkg::*;

  localparam int DW   = SAMPLE_BITS + FRAC_BITS;
  localparam int AW   = DW + 1;
  localparam int PW   = AW + COEF_BITS;
  localparam int CW   = ((SAMPLE_BITS + 1 > REG_BITS + 1) ? SAMPLE_BITS + 1 : REG_BITS + 1)
                        + FRAC_BITS;
  localparam int CMPW = (SAMPLE_BITS > CONTACT_BITS) ? SAMPLE_BITS : CONTACT_BITS;
  localparam int BPW  = BLEND_BITS + RECIP_BITS;

  hrd_cfg_t     cfg;
  hrd_div_req_t div_req;
  hrd_div_rsp_t div_rsp;
  hrd_state_e   state_q, state_d;

  logic [SAMPLE_BITS-1:0] ir_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [MOTION_BITS-1:0] motion_q;
  logic [DW-1:0]          dc_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [AW-1:0]   ac_q;
  logic signed [AW-1:0]   wave_peak_q;
  logic [BPM_BITS-1:0]    bpm_q;
  logic [BPM_BITS-1:0]    raw_q;
  logic [TIME_BITS-1:0]   last_q;
  logic                   have_last_q;

  logic                    res_seen_q, res_acc_q, res_nocon_q;
  logic signed [SAMPLE_BITS:0] res_ac_q;

  logic                    out_valid_q;
  logic [BPM_BITS-1:0]     out_bpm_q;
  logic signed [SAMPLE_BITS:0] out_ac_q;
  logic                    out_seen_q, out_acc_q, out_nocon_q;

  logic in_ready, in_fire, in_nocon, out_load;

  logic [DW-1:0]                   scaled;
  logic signed [AW-1:0]            dc_diff;
  logic signed [COEF_BITS-1:0]     coef;
  logic signed [PW-1:0]            prod_d;
  logic signed [PW-1:0]            prod_rnd;
  logic signed [PW-1:0]            dc_sum;
  logic [DW-1:0]                   dc_new;
  logic signed [AW-1:0]            ac_new;
  logic signed [AW-1:0]            ac_shr;

  logic signed [CW-1:0] ac_x, wp_x, peak_x, trough_x;
  logic                 above_peak, is_beat, qualify;
  logic [TIME_BITS-1:0] interval;
  logic [DIV_D_BITS-1:0] ivl;
  logic [DIV_N_BITS-1:0] raw_dividend;
  logic [BLEND_BITS-1:0] blend_sum;
  logic [BPW-1:0]        blend_prod;
  logic [BPM_BITS-1:0]   blend_quo;
  logic [BPM_BITS-1:0]   raw_sat, bpm_diff;
  logic                  accept_bpm;

  hrd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  hrd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // handshake
  assign in_fire  = in_i.valid && in_ready;
  assign in_nocon = CMPW'(in_i.ir_sample) <= CMPW'(cfg.contact);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // DC filter: dc' = dc + round((x - dc) * 0.01)
  assign scaled   = {ir_q, {FRAC_BITS{1'b0}}};
  assign dc_diff  = $signed({1'b0, scaled}) - $signed({1'b0, dc_q});
  assign coef     = COEF_BITS'(COEF_NEW);
  assign prod_d   = dc_diff * coef;
  assign prod_rnd = prod_q + $signed(PW'(ROUND_HALF));
  assign dc_sum   = $signed({{(PW-DW){1'b0}}, dc_q}) + (prod_rnd >>> COEF_SHIFT);
  assign dc_new   = dc_sum[DW-1:0];
  assign ac_new   = $signed({1'b0, scaled}) - $signed({1'b0, dc_new});
  assign ac_shr   = ac_new >>> FRAC_BITS;

  // peak and trough tests
  assign ac_x       = CW'(ac_q);
  assign wp_x       = CW'(wave_peak_q);
  assign peak_x     = $signed({{(CW-REG_BITS-FRAC_BITS){1'b0}}, cfg.peak, {FRAC_BITS{1'b0}}});
  assign trough_x   = -$signed({{(CW-REG_BITS-FRAC_BITS){1'b0}}, cfg.trough,
                                {FRAC_BITS{1'b0}}});
  assign above_peak = ac_x > peak_x;
  assign is_beat    = !above_peak && (ac_x < trough_x) && (wp_x > peak_x);

  assign interval = time_q - last_q;
  assign ivl      = interval[DIV_D_BITS-1:0];
  assign qualify  = have_last_q
                    && (interval > TIME_BITS'(cfg.min_ivl))
                    && (interval < TIME_BITS'(cfg.max_ivl))
                    && (motion_q < cfg.motion);

  assign raw_dividend = BPM_NUMER + DIV_N_BITS'(ivl >> 1);
  assign raw_sat      = (div_rsp.quotient[DIV_N_BITS-1:BPM_BITS] != '0) ? BPM_MAX
                        : div_rsp.quotient[BPM_BITS-1:0];
  assign bpm_diff     = (raw_q >= bpm_q) ? raw_q - bpm_q : bpm_q - raw_q;
  assign accept_bpm   = (bpm_diff < cfg.jump) || (bpm_q == cfg.init_bpm);
  assign blend_sum    = (BLEND_BITS'(bpm_q) << 1) + BLEND_BITS'(bpm_q)
                        + (BLEND_BITS'(raw_q) << 1) + BLEND_RND;

  // divide by five: multiply by the rounded-up reciprocal, drop the fraction
  assign blend_prod = BPW'(blend_sum) * BPW'(BLEND_RECIP);
  assign blend_quo  = blend_prod[RECIP_SHIFT +: BPM_BITS];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = in_nocon ? ST_OUT : ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_EVAL;
      ST_EVAL:  state_d = (is_beat && qualify) ? ST_RAW : ST_OUT;
      ST_RAW:   if (div_rsp.done) state_d = ST_JUDGE;
      ST_JUDGE: state_d = accept_bpm ? ST_BLEND : ST_OUT;
      ST_BLEND: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = raw_dividend;
    div_req.divisor  = ivl;
    unique case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_EVAL:  div_req.start = is_beat && qualify;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // filter and beat state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q        <= '0;
      wave_peak_q <= '0;
      bpm_q       <= RST_INIT_BPM;
      last_q      <= '0;
      have_last_q <= 1'b0;
      res_seen_q  <= 1'b0;
      res_acc_q   <= 1'b0;
      res_nocon_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            res_seen_q  <= 1'b0;
            res_acc_q   <= 1'b0;
            res_nocon_q <= in_nocon;
          end
        end
        ST_ACC: dc_q <= dc_new;
        ST_EVAL: begin
          if (above_peak) begin
            if (ac_x > wp_x) wave_peak_q <= ac_q;
          end else if (is_beat) begin
            res_seen_q  <= 1'b1;
            last_q      <= time_q;
            have_last_q <= 1'b1;
            wave_peak_q <= '0;
          end
        end
        ST_BLEND: begin
          bpm_q     <= blend_quo;
          res_acc_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // sample and working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ir_q     <= in_i.ir_sample;
          time_q   <= in_i.time_ms;
          motion_q <= in_i.motion_magnitude;
          res_ac_q <= '0;
        end
      end
      ST_MUL: prod_q <= prod_d;
      ST_ACC: begin
        ac_q     <= ac_new;
        res_ac_q <= ac_shr[SAMPLE_BITS:0];
      end
      ST_RAW: if (div_rsp.done) raw_q <= raw_sat;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bpm_q   <= bpm_q;
      out_ac_q    <= res_ac_q;
      out_seen_q  <= res_seen_q;
      out_acc_q   <= res_acc_q;
      out_nocon_q <= res_nocon_q;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.bpm_estimate  = out_bpm_q;
  assign out_o.ac_level      = out_ac_q;
  assign out_o.beat_seen     = out_seen_q;
  assign out_o.beat_accepted = out_acc_q;
  assign out_o.no_contact    = out_nocon_q;

  `include "ppg_heart_rate_detector_assert.svh"

  `HRD_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> state_q == ST_IDLE && !out_valid_q)
  `HRD_ASSERT(a_fire_leaves_idle, clk_i, rst_ni, in_fire |=> state_q != ST_IDLE)
  `HRD_ASSERT(a_bpm_only_blend, clk_i, rst_ni, !$stable(bpm_q) |-> $past(state_q) == ST_BLEND)
  `HRD_ASSERT(a_acc_needs_seen, clk_i, rst_ni, out_valid_q && out_acc_q |-> out_seen_q)
  `HRD_ASSERT(a_nocon_quiet, clk_i, rst_ni, out_valid_q && out_nocon_q |-> !out_seen_q && out_ac_q == '0)

endmodule
